// ----- hdl/kncs_pkg.sv -----
// ============================================================================
// Klein-Nishina evaluator package
// Shared constants, table and types for the Compton cross-section pipeline.
// ============================================================================
package kncs_pkg;

    // Default values for the top-level parameters.
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Field widths.
    localparam int ANGLE_W  = 16;
    localparam int ENERGY_W = 14;
    localparam int SCAT_W   = 22;
    localparam int RATIO_W  = 17;
    localparam int CS_W     = 17;
    localparam int PHI_W    = 31;
    localparam int MAG_W    = 31;

    // Q30 constants.
    localparam logic [31:0] Q30_ONE         = 32'd1073741824;
    localparam logic [31:0] PI_Q30          = 32'd3373259426;
    localparam logic [31:0] HALF_PI_Q30     = 32'd1686629713;
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

    // Electron rest energy in keV and half of it for rounding.
    localparam logic [9:0] REST_KEV      = 10'd511;
    localparam logic [9:0] HALF_REST_KEV = 10'd255;

    // Pipeline depth of the back end beyond the CORDIC rotations.
    localparam int BACK_FIXED_LAT = 41;

    // Depth of the queue between front and back end.
    localparam int MID_DEPTH = 4;

    // Rotation angles atan(2^-i) in Q30.
    localparam logic [31:0] ATAN_Q30 [24] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    // Classified angle handed from front to back end.
    typedef struct packed {
        logic             folded;
        logic [PHI_W-1:0] phi;
    } t_angle_item;

    // Cosine and sine magnitudes out of the CORDIC.
    typedef struct packed {
        logic             folded;
        logic [MAG_W-1:0] cos_mag;
        logic [MAG_W-1:0] sin_mag;
    } t_trig;

    // One result item.
    typedef struct packed {
        logic [SCAT_W-1:0]  photon_energy;
        logic [RATIO_W-1:0] energy_ratio;
        logic [CS_W-1:0]    cross_section;
    } t_result;

endpackage

// ----- hdl/klein_nishina_cross_section.sv -----
// ============================================================================
// Klein-Nishina cross-section evaluator
// Scattered energy, energy ratio and differential cross-section per angle.
// ============================================================================
// The block takes one scattering angle per clock cycle while o_full is low and
// returns one result per angle, in order. The latency is set by the CORDIC
// pipeline and by the long division of 2^60 by 1/r, which resolves one
// quotient bit per stage. Results wait in an output queue sized to cover that
// latency, so a stalled consumer only stops new angles once the queue and
// pipeline are full. The incident energy register resets to 511 keV and may be
// written only while no angle is in flight.
module klein_nishina_cross_section #(
    parameter int ANGLE_BITS    = kncs_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = kncs_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [kncs_pkg::ANGLE_W-1:0]  i_scatter_angle,
    input  logic                          i_cfg_wr_en,
    input  logic [kncs_pkg::ENERGY_W-1:0] i_incident_energy_kev,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [kncs_pkg::SCAT_W-1:0]   o_photon_energy,
    output logic [kncs_pkg::RATIO_W-1:0]  o_energy_ratio,
    output logic [kncs_pkg::CS_W-1:0]     o_cross_section
);
    import kncs_pkg::*;

    localparam int LATENCY   = CORDIC_STAGES + BACK_FIXED_LAT;
    localparam int OUT_DEPTH = 1 << $clog2(LATENCY + 2);
    localparam int UW        = $clog2(OUT_DEPTH + 1);

    logic [ENERGY_W-1:0] r_energy;
    logic                q_push;
    t_angle_item         q_in;
    logic                q_full;
    logic                q_empty;
    t_angle_item         q_out;
    logic                issue;
    logic                b_valid;
    t_result             b_result;
    t_result             out_data;
    logic                out_pop;
    logic                out_full;
    logic [UW-1:0]       r_used;

    // Incident energy register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_energy <= ENERGY_W'(511);
        end else if (i_cfg_wr_en) begin
            r_energy <= i_incident_energy_kev;
        end
    end

    kncs_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .o_full          (o_full),
        .i_scatter_angle (i_scatter_angle),
        .o_q_push        (q_push),
        .o_q_item        (q_in),
        .i_q_full        (q_full)
    );

    kncs_fifo #(.WIDTH($bits(t_angle_item)), .DEPTH(MID_DEPTH)) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (issue),
        .o_empty (q_empty),
        .o_data  (q_out)
    );

    // An angle enters the back end only when its result has a reserved slot.
    assign issue   = !q_empty && (r_used < UW'(OUT_DEPTH));
    assign out_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (issue && !out_pop) begin
            r_used <= r_used + 1'b1;
        end else if (!issue && out_pop) begin
            r_used <= r_used - 1'b1;
        end
    end

    kncs_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (issue),
        .i_item   (q_out),
        .i_energy (r_energy),
        .o_valid  (b_valid),
        .o_result (b_result)
    );

    kncs_fifo #(.WIDTH($bits(t_result)), .DEPTH(OUT_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid),
        .i_data  (b_result),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (out_data)
    );

    assign o_photon_energy = out_data.photon_energy;
    assign o_energy_ratio  = out_data.energy_ratio;
    assign o_cross_section = out_data.cross_section;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= UW'(OUT_DEPTH))
        else $error("reserved result slots beyond queue depth");
    a_result_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (r_used != '0))
        else $error("result shown without a reserved slot");
    a_issue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> !q_empty)
        else $error("back end issued from an empty queue");
    a_out_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_valid |-> !out_full)
        else $error("result arrived at a full output queue");
`endif
endmodule

// ----- hdl/kncs_fifo.sv -----
// ============================================================================
// Klein-Nishina queue
// First-word-fall-through queue with a memory and a registered read stage.
// ============================================================================
module kncs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic [AW:0]      n_count;
    logic             r_ov;
    logic [WIDTH-1:0] r_odata;
    logic             wr;
    logic             rd;

    // A stored entry refills the output register when it is free or drained.
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign wr      = i_push && !o_full;
    assign rd      = (r_count != '0) && (!r_ov || i_pop);
    assign o_empty = !r_ov;
    assign o_data  = r_odata;

    always_comb begin
        n_count = r_count;
        if (wr && !rd) begin
            n_count = r_count + 1'b1;
        end else if (!wr && rd) begin
            n_count = r_count - 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_count <= n_count;
            if (wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_ov     <= 1'b1;
            end else if (i_pop && r_ov) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Memory write and registered read.
    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (rd) begin
            r_odata <= r_mem[r_rd_ptr];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (AW+1)'(DEPTH))
        else $error("queue count beyond depth");
    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |=> !o_empty)
        else $error("stored entry not presented at the output");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");
`endif
endmodule

// ----- hdl/kncs_front.sv -----
// ============================================================================
// Klein-Nishina front end
// Scales the angle code to Q30 radians and folds it into the first quadrant.
// ============================================================================
module kncs_front #(
    parameter int ANGLE_BITS = kncs_pkg::ANGLE_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    output logic                        o_full,
    input  logic [kncs_pkg::ANGLE_W-1:0] i_scatter_angle,
    output logic                        o_q_push,
    output kncs_pkg::t_angle_item       o_q_item,
    input  logic                        i_q_full
);
    import kncs_pkg::*;

    logic [ANGLE_BITS-1:0]    code;
    logic [ANGLE_BITS+31:0]   prod;
    logic                     r_v;
    logic [31:0]              r_theta;
    logic                     advance;
    logic                     folded;
    logic [31:0]              phi_full;

    // Only the low ANGLE_BITS bits of the code count.
    assign code    = ANGLE_BITS'(i_scatter_angle);
    assign prod    = (ANGLE_BITS+32)'(code) * (ANGLE_BITS+32)'(PI_Q30);
    assign advance = !r_v || !i_q_full;
    assign o_full  = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (advance) begin
            r_v <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_push) begin
            r_theta <= prod[ANGLE_BITS +: 32];
        end
    end

    // Angles past a right angle are mirrored; the cosine sign flips later.
    assign folded            = r_theta > HALF_PI_Q30;
    assign phi_full          = folded ? (PI_Q30 - r_theta) : r_theta;
    assign o_q_push          = r_v && !i_q_full;
    assign o_q_item.folded   = folded;
    assign o_q_item.phi      = phi_full[PHI_W-1:0];
endmodule

// ----- hdl/kncs_cordic.sv -----
// ============================================================================
// Klein-Nishina CORDIC
// Pipelined rotation-mode CORDIC giving clamped cosine and sine magnitudes.
// ============================================================================
module kncs_cordic #(
    parameter int STAGES = kncs_pkg::CORDIC_STAGES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  kncs_pkg::t_angle_item i_item,
    output logic                  o_valid,
    output kncs_pkg::t_trig       o_trig
);
    import kncs_pkg::*;

    localparam int CW = 34;

    logic signed [CW-1:0] r_x [STAGES];
    logic signed [CW-1:0] r_y [STAGES];
    logic signed [CW-1:0] r_z [STAGES];
    logic                 r_f [STAGES];
    logic                 r_v [STAGES];
    logic                 r_ov;
    t_trig                r_trig;
    logic [MAG_W-1:0]     c_mag;
    logic [MAG_W-1:0]     s_mag;

    // One rotation per stage, direction from the sign of the residual angle.
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [CW-1:0] z_in;
        logic                 f_in;
        logic                 v_in;
        logic signed [CW-1:0] atan_g;
        logic signed [CW-1:0] n_x;
        logic signed [CW-1:0] n_y;
        logic signed [CW-1:0] n_z;

        if (g == 0) begin : g_first
            assign x_in = CW'(CORDIC_GAIN_Q30);
            assign y_in = '0;
            assign z_in = CW'(i_item.phi);
            assign f_in = i_item.folded;
            assign v_in = i_valid;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
            assign f_in = r_f[g-1];
            assign v_in = r_v[g-1];
        end

        assign atan_g = CW'(ATAN_Q30[g]);

        always_comb begin
            if (!z_in[CW-1]) begin
                n_x = x_in - (y_in >>> g);
                n_y = y_in + (x_in >>> g);
                n_z = z_in - atan_g;
            end else begin
                n_x = x_in + (y_in >>> g);
                n_y = y_in - (x_in >>> g);
                n_z = z_in + atan_g;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_x[g] <= n_x;
            r_y[g] <= n_y;
            r_z[g] <= n_z;
            r_f[g] <= f_in;
        end
    end

    // Clamp both magnitudes to the unit interval.
    always_comb begin
        if (r_x[STAGES-1][CW-1]) begin
            c_mag = '0;
        end else if (r_x[STAGES-1] > CW'(Q30_ONE)) begin
            c_mag = MAG_W'(Q30_ONE);
        end else begin
            c_mag = r_x[STAGES-1][MAG_W-1:0];
        end
        if (r_y[STAGES-1][CW-1]) begin
            s_mag = '0;
        end else if (r_y[STAGES-1] > CW'(Q30_ONE)) begin
            s_mag = MAG_W'(Q30_ONE);
        end else begin
            s_mag = r_y[STAGES-1][MAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= r_v[STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_trig.folded  <= r_f[STAGES-1];
        r_trig.cos_mag <= c_mag;
        r_trig.sin_mag <= s_mag;
    end

    assign o_valid = r_ov;
    assign o_trig  = r_trig;
endmodule

// ----- hdl/kncs_back.sv -----
// ============================================================================
// Klein-Nishina back end
// CORDIC, 1/r, the long divisions by 1/r and the cross-section products.
// ============================================================================
module kncs_back #(
    parameter int CORDIC_STAGES = kncs_pkg::CORDIC_STAGES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  kncs_pkg::t_angle_item         i_item,
    input  logic [kncs_pkg::ENERGY_W-1:0] i_energy,
    output logic                          o_valid,
    output kncs_pkg::t_result             o_result
);
    import kncs_pkg::*;

    localparam int D5_BITS  = 47;
    localparam int D5_STG   = 3;
    localparam int D5_ITER  = 2;
    localparam int DW       = 37;
    localparam int Q_STEPS  = 31;
    localparam int E_STEPS  = SCAT_W;
    localparam int RATIO_AT = 17;

    typedef struct packed {
        logic [DW-1:0]      acc;
        logic [D5_BITS-1:0] m;
        logic [MAG_W-1:0]   s;
    } t_d5;

    typedef struct packed {
        logic [DW-1:0]      d;
        logic [DW-1:0]      rem;
        logic [Q_STEPS-1:0] q;
        logic [DW-1:0]      erem;
        logic [E_STEPS-1:0] eq;
        logic [MAG_W-1:0]   s;
        logic [RATIO_W-1:0] ratio;
        logic [SCAT_W-1:0]  energy;
    } t_dv;

    logic             cv;
    t_trig            trig;
    logic [31:0]      omc;
    logic             r_v1;
    logic [46:0]      r_p;
    logic [MAG_W-1:0] r_s1;
    t_d5              r_d5 [D5_STG];
    logic             r_d5v [D5_STG];
    logic             r_dv0;
    t_dv              r_d0;
    t_dv              r_dv [Q_STEPS];
    logic             r_dvv [Q_STEPS];
    logic [DW-1:0]    q511;

    kncs_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (cv),
        .o_trig  (trig)
    );

    // 1 - cos(theta), then E times it plus half of 511 for rounding.
    assign omc = trig.folded ? (Q30_ONE + 32'(trig.cos_mag))
                             : (Q30_ONE - 32'(trig.cos_mag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= cv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p  <= 47'(i_energy) * 47'(omc) + 47'(HALF_REST_KEV);
        r_s1 <= trig.sin_mag;
    end

    // Division by 511 = 2^9 - 1. Each fold moves the part above bit 9 into
    // the quotient and adds it back onto the low nine bits, which keeps
    // 511 * acc + m constant. Six folds leave m at most 511, and the last
    // stage counts m == 511 as one more quotient unit.
    for (genvar g = 0; g < D5_STG; g++) begin : g_d5
        t_d5                in_d;
        logic               v_in;
        t_d5                n_d;
        logic [D5_BITS-1:0] hi;

        if (g == 0) begin : g_first
            assign in_d.acc = '0;
            assign in_d.m   = r_p;
            assign in_d.s   = r_s1;
            assign v_in     = r_v1;
        end else begin : g_next
            assign in_d = r_d5[g-1];
            assign v_in = r_d5v[g-1];
        end

        always_comb begin
            n_d = in_d;
            hi  = '0;
            for (int k = 0; k < D5_ITER; k++) begin
                hi      = n_d.m >> 9;
                n_d.acc = n_d.acc + hi[DW-1:0];
                n_d.m   = hi + {{(D5_BITS-9){1'b0}}, n_d.m[8:0]};
            end
            if (g == D5_STG - 1) begin
                n_d.acc = n_d.acc + DW'(n_d.m == D5_BITS'(REST_KEV));
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d5v[g] <= 1'b0;
            end else begin
                r_d5v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_d5[g] <= n_d;
        end
    end

    // 1/r in Q30 and the starting remainders of both long divisions.
    assign q511 = r_d5[D5_STG-1].acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv0 <= 1'b0;
        end else begin
            r_dv0 <= r_d5v[D5_STG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_d0.d      <= DW'(Q30_ONE) + q511;
        r_d0.rem    <= DW'(1) << 29;
        r_d0.q      <= '0;
        r_d0.erem   <= DW'(i_energy) << 16;
        r_d0.eq     <= '0;
        r_d0.s      <= r_d5[D5_STG-1].s;
        r_d0.ratio  <= '0;
        r_d0.energy <= '0;
    end

    // One quotient bit of 2^60/d per stage; 2^46/d and E*2^38/d ride along.
    for (genvar g = 0; g < Q_STEPS; g++) begin : g_div
        t_dv         in_d;
        logic        v_in;
        t_dv         n_d;
        logic [DW:0] t;
        logic [DW:0] et;
        logic        ge;
        logic        ege;
        logic [DW-1:0] half_up;
        logic [RATIO_W:0] rsum;
        logic [SCAT_W:0]  esum;

        if (g == 0) begin : g_first
            assign in_d = r_d0;
            assign v_in = r_dv0;
        end else begin : g_next
            assign in_d = r_dv[g-1];
            assign v_in = r_dvv[g-1];
        end

        assign half_up = in_d.d - (in_d.d >> 1);

        always_comb begin
            n_d   = in_d;
            t     = {in_d.rem, 1'b0};
            ge    = t >= {1'b0, in_d.d};
            n_d.rem = ge ? DW'(t - {1'b0, in_d.d}) : t[DW-1:0];
            n_d.q   = {in_d.q[Q_STEPS-2:0], ge};
            et    = {in_d.erem, 1'b0};
            ege   = 1'b0;
            rsum  = '0;
            esum  = '0;
            if (g < E_STEPS) begin
                ege      = et >= {1'b0, in_d.d};
                n_d.erem = ege ? DW'(et - {1'b0, in_d.d}) : et[DW-1:0];
                n_d.eq   = {in_d.eq[E_STEPS-2:0], ege};
            end
            if (g == RATIO_AT) begin
                rsum = (RATIO_W+1)'(in_d.q[RATIO_W-1:0])
                     + (RATIO_W+1)'(in_d.rem >= half_up);
                n_d.ratio = (rsum > (RATIO_W+1)'(65536)) ? RATIO_W'(65536)
                                                          : rsum[RATIO_W-1:0];
            end
            if (g == E_STEPS) begin
                esum = (SCAT_W+1)'(in_d.eq) + (SCAT_W+1)'(in_d.erem >= half_up);
                n_d.energy = esum[SCAT_W] ? {SCAT_W{1'b1}} : esum[SCAT_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[g] <= 1'b0;
            end else begin
                r_dvv[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv[g] <= n_d;
        end
    end

    // Rounded r, then r^2, sin^2, r^3 and r^2 sin^2, then the sum.
    logic               r_vr;
    logic [MAG_W-1:0]   r_rq;
    logic [MAG_W-1:0]   r_sr;
    logic [RATIO_W-1:0] r_ratio_r;
    logic [SCAT_W-1:0]  r_energy_r;
    logic [DW-1:0]      fin_half;

    assign fin_half = r_dv[Q_STEPS-1].d - (r_dv[Q_STEPS-1].d >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vr <= 1'b0;
        end else begin
            r_vr <= r_dvv[Q_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_rq       <= r_dv[Q_STEPS-1].q + MAG_W'(r_dv[Q_STEPS-1].rem >= fin_half);
        r_sr       <= r_dv[Q_STEPS-1].s;
        r_ratio_r  <= r_dv[Q_STEPS-1].ratio;
        r_energy_r <= r_dv[Q_STEPS-1].energy;
    end

    logic               r_vm1;
    logic [MAG_W-1:0]   r_r2;
    logic [MAG_W-1:0]   r_s2;
    logic [MAG_W-1:0]   r_rq1;
    logic [RATIO_W-1:0] r_ratio_m1;
    logic [SCAT_W-1:0]  r_energy_m1;
    logic [61:0]        p_r2;
    logic [61:0]        p_s2;

    assign p_r2 = 62'(r_rq) * 62'(r_rq) + (62'(1) << 29);
    assign p_s2 = 62'(r_sr) * 62'(r_sr) + (62'(1) << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm1 <= 1'b0;
        end else begin
            r_vm1 <= r_vr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2        <= p_r2[60:30];
        r_s2        <= p_s2[60:30];
        r_rq1       <= r_rq;
        r_ratio_m1  <= r_ratio_r;
        r_energy_m1 <= r_energy_r;
    end

    logic               r_vm2;
    logic [MAG_W-1:0]   r_r3;
    logic [MAG_W-1:0]   r_rs2;
    logic [MAG_W-1:0]   r_rq2;
    logic [RATIO_W-1:0] r_ratio_m2;
    logic [SCAT_W-1:0]  r_energy_m2;
    logic [61:0]        p_r3;
    logic [61:0]        p_rs2;

    assign p_r3  = 62'(r_r2) * 62'(r_rq1) + (62'(1) << 29);
    assign p_rs2 = 62'(r_r2) * 62'(r_s2) + (62'(1) << 29);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm2 <= 1'b0;
        end else begin
            r_vm2 <= r_vm1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r3        <= p_r3[60:30];
        r_rs2       <= p_rs2[60:30];
        r_rq2       <= r_rq1;
        r_ratio_m2  <= r_ratio_m1;
        r_energy_m2 <= r_energy_m1;
    end

    logic        r_vo;
    t_result     r_res;
    logic [32:0] pos;
    logic [32:0] diff;
    logic [17:0] cs_full;
    logic [CS_W-1:0] cs;

    // Cross-section: (r^3 + r - r^2 sin^2) / 2, clamped to [0, 1].
    always_comb begin
        pos     = 33'(r_r3) + 33'(r_rq2) + (33'(1) << 14);
        diff    = pos - 33'(r_rs2);
        cs_full = (pos > 33'(r_rs2)) ? diff[32:15] : '0;
        cs      = (cs_full > 18'(65536)) ? CS_W'(65536) : cs_full[CS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_vm2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.photon_energy <= r_energy_m2;
        r_res.energy_ratio  <= r_ratio_m2;
        r_res.cross_section <= cs;
    end

    assign o_valid  = r_vo;
    assign o_result = r_res;
endmodule
